>>> rtl/pidmpc_pkg.sv
// Shared types, constants and the control-store contents of the PID position controller.
// No dependencies; used by pid_motor_position_controller.
package pidmpc_pkg;

  localparam int unsigned US_PER_S = 1000000;
  localparam logic [19:0] MILLION  = 20'(US_PER_S);

  localparam logic [15:0] PGAIN_RST = 16'd256;
  localparam logic [15:0] DGAIN_RST = 16'd0;
  localparam logic [15:0] IGAIN_RST = 16'd0;
  localparam logic [7:0]  LIMIT_RST = 8'd255;

  localparam logic [1:0] REG_PGAIN = 2'd0;
  localparam logic [1:0] REG_DGAIN = 2'd1;
  localparam logic [1:0] REG_IGAIN = 2'd2;
  localparam logic [1:0] REG_LIMIT = 2'd3;

  localparam int          STEP_W    = 4;
  localparam logic [3:0]  STEP_LAST = 4'd15;

  // divider double-steps minus one: 38-, 64- and 36-bit quotients
  localparam int          DIV_CNT_W    = 5;
  localparam logic [4:0]  DIV_IT_RATE  = 5'd18;
  localparam logic [4:0]  DIV_IT_INTEG = 5'd31;
  localparam logic [4:0]  DIV_IT_IREM  = 5'd17;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } seq_state_t;

  typedef enum logic [2:0] {
    MA_ERR, MA_DIFF, MA_PGAIN, MA_DGAIN, MA_IGAIN
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_DT, MB_MILLION, MB_ERR, MB_QLO, MB_QHI, MB_REM
  } mul_b_t;

  typedef enum logic [1:0] {
    DL_NONE, DL_RATE, DL_INTEG, DL_IREM
  } div_ld_t;

  typedef enum logic [2:0] {
    AC_NONE, AC_CLR, AC_LO, AC_HI, AC_DIV
  } acc_op_t;

  typedef enum logic [1:0] {
    SG_ERR, SG_DIFF, SG_INTEG
  } sgn_t;

  typedef enum logic [1:0] {
    JC_NEXT, JC_WAIT, JC_DONE
  } jmp_t;

  typedef struct packed {
    mul_a_t  ma;
    mul_b_t  mb;
    logic    mul_en;
    div_ld_t dl;
    acc_op_t ac;
    sgn_t    sg;
    logic    integ_upd;
    jmp_t    jc;
  } uop_t;

  localparam uop_t UOP_NOP = '{
    ma: MA_ERR, mb: MB_DT, mul_en: 1'b0, dl: DL_NONE,
    ac: AC_NONE, sg: SG_ERR, integ_upd: 1'b0, jc: JC_NEXT
  };

  function automatic uop_t ucode(input logic [STEP_W-1:0] step);
    uop_t u;
    u = UOP_NOP;
    case (step)
      4'd0: begin
        u.ma = MA_ERR;   u.mb = MB_DT;      u.mul_en = 1'b1; u.ac = AC_CLR;
      end
      4'd1: begin
        u.integ_upd = 1'b1;
        u.ma = MA_DIFF;  u.mb = MB_MILLION; u.mul_en = 1'b1;
      end
      4'd2: begin
        u.dl = DL_RATE;
        u.ma = MA_PGAIN; u.mb = MB_ERR;     u.mul_en = 1'b1;
      end
      4'd3: begin
        u.ac = AC_LO;    u.sg = SG_ERR;
      end
      4'd4: begin
        u.jc = JC_WAIT;
      end
      4'd5: begin
        u.ma = MA_DGAIN; u.mb = MB_QLO;     u.mul_en = 1'b1;
      end
      4'd6: begin
        u.ma = MA_DGAIN; u.mb = MB_QHI;     u.mul_en = 1'b1;
        u.ac = AC_LO;    u.sg = SG_DIFF;
      end
      4'd7: begin
        u.ac = AC_HI;    u.sg = SG_DIFF;    u.dl = DL_INTEG;
      end
      4'd8: begin
        u.jc = JC_WAIT;
      end
      4'd9: begin
        u.ma = MA_IGAIN; u.mb = MB_QLO;     u.mul_en = 1'b1;
      end
      4'd10: begin
        u.ma = MA_IGAIN; u.mb = MB_QHI;     u.mul_en = 1'b1;
        u.ac = AC_LO;    u.sg = SG_INTEG;
      end
      4'd11: begin
        u.ma = MA_IGAIN; u.mb = MB_REM;     u.mul_en = 1'b1;
        u.ac = AC_HI;    u.sg = SG_INTEG;
      end
      4'd12: begin
        u.dl = DL_IREM;
      end
      4'd13: begin
        u.jc = JC_WAIT;
      end
      4'd14: begin
        u.ac = AC_DIV;   u.sg = SG_INTEG;
      end
      4'd15: begin
        u.jc = JC_DONE;
      end
      default: begin
        u = UOP_NOP;
      end
    endcase
    return u;
  endfunction

endpackage

>>> rtl/pid_motor_position_controller.sv
// PID position controller: microcoded sequencer, 17x24 multiplier, radix-4 divider.
// Depends on pidmpc_pkg (control store, codes, reset values).
//
// One item is one control tick. The block forms error = target - position, adds error * dt
// to a saturating 64-bit integral, and sums P, D (error slope per second) and I terms
// weighted by unsigned Q8.8 gains; the result is the truncated magnitude of the sum in
// whole units, clamped to power_limit, plus a direction bit. A new item is accepted only
// while idle, after the previous item's program has ended; its last step holds until the
// output register is free. The one shared divider yields two quotient bits per cycle
// for the 38-bit slope quotient, the 64-bit integral split by one million and the
// 36-bit integral remainder term; the 16-step control program sequences it and the
// multiplier. Gains and the limit sit on an APB port at byte addresses 0, 4, 8 and 12.
module pid_motor_position_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_measured_position,
  input  logic signed [15:0] in_target_position,
  input  logic [19:0]        in_elapsed_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_drive_power,
  output logic               out_reverse,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration
  logic [15:0] pgain_r, dgain_r, igain_r;
  logic [7:0]  power_limit_r;
  logic        cfg_wr;

  // sequencer
  pidmpc_pkg::seq_state_t            seq_r, seq_nxt;
  logic [pidmpc_pkg::STEP_W-1:0]     step_r, step_nxt;
  pidmpc_pkg::uop_t                  uop;
  logic                              in_acc, done;

  // tick operands and state
  logic signed [16:0] err_r, last_err_r;
  logic signed [17:0] diff_r;
  logic [19:0]        dt_r;
  logic [15:0]        err_mag;
  logic [16:0]        diff_mag;
  logic signed [63:0] integ_r, integ_nxt;
  logic signed [64:0] isum, iterm;

  // multiplier
  logic [16:0] mx;
  logic [23:0] my;
  logic [40:0] prod_r;

  // divider
  logic [63:0]                       div_q_r, div_q_nxt;
  logic [19:0]                       div_rem_r, div_rem_nxt, div_d_r, div_d_nxt;
  logic                              div_busy_r, div_busy_nxt;
  logic [pidmpc_pkg::DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic [20:0]                       dv_r1, dv_r2;
  logic [19:0]                       dv_s1, dv_s2;
  logic                              dv_g1, dv_g2;

  // accumulator and result
  logic signed [63:0] acc_r, acc_nxt;
  logic [63:0]        tm, s_mag;
  logic               tneg;
  logic               out_valid_r;
  logic [7:0]         drive_r, drive_nxt;
  logic               rev_r;

  // ---------------- configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pgain_r       <= pidmpc_pkg::PGAIN_RST;
      dgain_r       <= pidmpc_pkg::DGAIN_RST;
      igain_r       <= pidmpc_pkg::IGAIN_RST;
      power_limit_r <= pidmpc_pkg::LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        pidmpc_pkg::REG_PGAIN: pgain_r       <= pwdata[15:0];
        pidmpc_pkg::REG_DGAIN: dgain_r       <= pwdata[15:0];
        pidmpc_pkg::REG_IGAIN: igain_r       <= pwdata[15:0];
        pidmpc_pkg::REG_LIMIT: power_limit_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pidmpc_pkg::REG_PGAIN: prdata = {16'd0, pgain_r};
      pidmpc_pkg::REG_DGAIN: prdata = {16'd0, dgain_r};
      pidmpc_pkg::REG_IGAIN: prdata = {16'd0, igain_r};
      pidmpc_pkg::REG_LIMIT: prdata = {24'd0, power_limit_r};
      default:               prdata = '0;
    endcase
  end

  // ---------------- sequencer
  assign in_ready = (seq_r == pidmpc_pkg::S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign uop      = pidmpc_pkg::ucode(step_r);
  assign done     = (seq_r == pidmpc_pkg::S_RUN) && (uop.jc == pidmpc_pkg::JC_DONE) &&
                    (!out_valid_r || out_ready);

  always_comb begin
    seq_nxt  = seq_r;
    step_nxt = step_r;
    case (seq_r)
      pidmpc_pkg::S_IDLE: begin
        if (in_acc) begin
          seq_nxt  = pidmpc_pkg::S_RUN;
          step_nxt = '0;
        end
      end
      pidmpc_pkg::S_RUN: begin
        case (uop.jc)
          pidmpc_pkg::JC_NEXT: step_nxt = step_r + 1'b1;
          pidmpc_pkg::JC_WAIT: if (!div_busy_r) step_nxt = step_r + 1'b1;
          pidmpc_pkg::JC_DONE: if (done) seq_nxt = pidmpc_pkg::S_IDLE;
          default: ;
        endcase
      end
      default: seq_nxt = pidmpc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= pidmpc_pkg::S_IDLE;
      step_r <= '0;
    end else begin
      seq_r  <= seq_nxt;
      step_r <= step_nxt;
    end
  end

  // ---------------- tick capture and error state
  always_ff @(posedge clk) begin
    if (in_acc) begin
      err_r  <= 17'({in_target_position[15], in_target_position}
                  - {in_measured_position[15], in_measured_position});
      diff_r <= {in_target_position[15], in_target_position[15], in_target_position}
              - {in_measured_position[15], in_measured_position[15], in_measured_position}
              - {last_err_r[16], last_err_r};
      dt_r   <= in_elapsed_us;
    end
  end

  assign err_mag  = err_r[16] ? 16'(-err_r) : err_r[15:0];
  assign diff_mag = diff_r[17] ? 17'(-diff_r) : diff_r[16:0];

  always_comb begin
    iterm = {29'd0, prod_r[35:0]};
    if (err_r[16]) iterm = -iterm;
    isum = {integ_r[63], integ_r} + iterm;
    if (isum[64] != isum[63])
      integ_nxt = isum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else
      integ_nxt = isum[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      integ_r    <= '0;
    end else begin
      if (uop.integ_upd && seq_r == pidmpc_pkg::S_RUN) integ_r <= integ_nxt;
      if (done) last_err_r <= err_r;
    end
  end

  // ---------------- multiplier, registered product
  always_comb begin
    case (uop.ma)
      pidmpc_pkg::MA_ERR:   mx = {1'b0, err_mag};
      pidmpc_pkg::MA_DIFF:  mx = diff_mag;
      pidmpc_pkg::MA_PGAIN: mx = {1'b0, pgain_r};
      pidmpc_pkg::MA_DGAIN: mx = {1'b0, dgain_r};
      pidmpc_pkg::MA_IGAIN: mx = {1'b0, igain_r};
      default:              mx = '0;
    endcase
    case (uop.mb)
      pidmpc_pkg::MB_DT:      my = {4'd0, dt_r};
      pidmpc_pkg::MB_MILLION: my = {4'd0, pidmpc_pkg::MILLION};
      pidmpc_pkg::MB_ERR:     my = {8'd0, err_mag};
      pidmpc_pkg::MB_QLO:     my = div_q_r[23:0];
      pidmpc_pkg::MB_QHI:     my = div_q_r[47:24];
      pidmpc_pkg::MB_REM:     my = {4'd0, div_rem_r};
      default:                my = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (uop.mul_en) prod_r <= 41'(mx) * 41'(my);
  end

  // ---------------- divider: restoring, two quotient bits per cycle, dividend left-aligned
  always_comb begin
    dv_r1 = {div_rem_r, div_q_r[63]};
    dv_g1 = dv_r1 >= {1'b0, div_d_r};
    dv_s1 = dv_g1 ? 20'(dv_r1 - {1'b0, div_d_r}) : dv_r1[19:0];
    dv_r2 = {dv_s1, div_q_r[62]};
    dv_g2 = dv_r2 >= {1'b0, div_d_r};
    dv_s2 = dv_g2 ? 20'(dv_r2 - {1'b0, div_d_r}) : dv_r2[19:0];

    div_q_nxt    = div_q_r;
    div_rem_nxt  = div_rem_r;
    div_d_nxt    = div_d_r;
    div_busy_nxt = div_busy_r;
    div_cnt_nxt  = div_cnt_r;

    if (seq_r == pidmpc_pkg::S_RUN && uop.dl != pidmpc_pkg::DL_NONE) begin
      div_rem_nxt  = '0;
      div_busy_nxt = 1'b1;
      div_d_nxt    = pidmpc_pkg::MILLION;
      case (uop.dl)
        pidmpc_pkg::DL_RATE: begin
          div_q_nxt   = {prod_r[37:0], 26'd0};
          div_d_nxt   = (dt_r == '0) ? 20'd1 : dt_r;
          div_cnt_nxt = pidmpc_pkg::DIV_IT_RATE;
        end
        pidmpc_pkg::DL_INTEG: begin
          div_q_nxt   = integ_r[63] ? 64'(-integ_r) : integ_r;
          div_cnt_nxt = pidmpc_pkg::DIV_IT_INTEG;
        end
        pidmpc_pkg::DL_IREM: begin
          div_q_nxt   = {prod_r[35:0], 28'd0};
          div_cnt_nxt = pidmpc_pkg::DIV_IT_IREM;
        end
        default: ;
      endcase
    end else if (div_busy_r) begin
      div_q_nxt   = {div_q_r[61:0], dv_g1, dv_g2};
      div_rem_nxt = dv_s2;
      if (div_cnt_r == '0) div_busy_nxt = 1'b0;
      else                 div_cnt_nxt  = div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else begin
      div_busy_r <= div_busy_nxt;
      div_cnt_r  <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    div_d_r   <= div_d_nxt;
  end

  // ---------------- signed accumulator of magnitude terms
  always_comb begin
    case (uop.sg)
      pidmpc_pkg::SG_ERR:   tneg = err_r[16];
      pidmpc_pkg::SG_DIFF:  tneg = diff_r[17];
      pidmpc_pkg::SG_INTEG: tneg = integ_r[63];
      default:              tneg = 1'b0;
    endcase
    case (uop.ac)
      pidmpc_pkg::AC_LO:  tm = {23'd0, prod_r};
      pidmpc_pkg::AC_HI:  tm = {prod_r[39:0], 24'd0};
      pidmpc_pkg::AC_DIV: tm = div_q_r;
      default:            tm = '0;
    endcase
    case (uop.ac)
      pidmpc_pkg::AC_CLR: acc_nxt = '0;
      pidmpc_pkg::AC_LO,
      pidmpc_pkg::AC_HI,
      pidmpc_pkg::AC_DIV: acc_nxt = tneg ? acc_r - $signed(tm) : acc_r + $signed(tm);
      default:            acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (seq_r == pidmpc_pkg::S_RUN) acc_r <= acc_nxt;
  end

  // ---------------- result register
  assign s_mag     = acc_r[63] ? (64'd0 - acc_r) : acc_r;
  assign drive_nxt = ((|s_mag[63:16]) || (s_mag[15:8] > power_limit_r)) ?
                     power_limit_r : s_mag[15:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      drive_r <= drive_nxt;
      rev_r   <= acc_r[63];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_power = drive_r;
  assign out_reverse     = rev_r;

  // ---------------- checks
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == pidmpc_pkg::S_IDLE |-> !div_busy_r)
    else $error("divider busy while sequencer idle");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> seq_r == pidmpc_pkg::S_RUN && step_r == '0)
    else $error("accepted item did not start program");

  a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(step_r) == pidmpc_pkg::STEP_LAST)
    else $error("result raised outside last step");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive_power <= power_limit_r)
    else $error("drive power above limit");

endmodule
